### rtl/cdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and codes for the circular deque
// Request and status codes, field widths and the controller-to-datapath
// command bundle.
// ----------------------------------------------------------------------------
package cdq_pkg;

    // Fixed field widths
    localparam int CFG_W  = 5;  // capacity register
    localparam int ACT_W  = 2;  // request code
    localparam int STAT_W = 2;  // result status

    // Reset value of the capacity register
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_REAR  = 2'd0,
        ACT_POP_REAR   = 2'd1,
        ACT_PUSH_FRONT = 2'd2,
        ACT_POP_FRONT  = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic exec;   // request accepted: update pointers, write and read store
        logic load;   // move pending result into the output register
    } cdq_cmd_t;

endpackage : cdq_pkg
`default_nettype wire

### rtl/circular_deque_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_unit: double-ended queue in a circular word store
// Push/pop at either end; overflow and underflow reported per request.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Contents
//  s_*       in   s_tvalid/s_tready  tuser = action, tdata = data_in
//  m_*       out  m_tvalid/m_tready  tdata = data_out, tuser = status
//  cfg_*     in   cfg_we             cfg_wdata = capacity (empties the queue)
//
//  Each request passes through the accept and pointer update, then the
//  registered store read. A new request is taken while the previous
//  result still waits in the output register; a stalled m_tready holds the
//  sequencer in its read state until the output register frees up.
//  Reset (aresetn low, synchronous): queue empty, capacity min(16, DEPTH),
//  no result pending. Store contents are not cleared.
//
module circular_deque_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // Capacity register
    input  wire logic                           cfg_we,
    input  wire logic [cdq_pkg::CFG_W-1:0]      cfg_wdata,

    // Request stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0] s_tdata,  // [DATA_WIDTH-1:0] data_in
    input  wire logic [cdq_pkg::ACT_W-1:0]      s_tuser,   // [1:0] action

    // Result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_tdata,   // [DATA_WIDTH-1:0] data_out
    output logic [cdq_pkg::STAT_W-1:0]          m_tuser    // [1:0] status
);
    import cdq_pkg::*;

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    cdq_cmd_t              cmd;
    logic [DATA_WIDTH-1:0] rsp_data;
    logic [STAT_W-1:0]     rsp_status;

    // Sequencer: handshakes and output-valid
    cdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Pointers, store and result registers
    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_action (s_tuser),
        .req_data   (s_tdata[DATA_WIDTH-1:0]),
        .rsp_data   (rsp_data),
        .rsp_status (rsp_status)
    );

    // Zero-pad the result word up to whole bytes
    assign m_tdata = TDATA_W'(rsp_data);
    assign m_tuser = rsp_status;

endmodule : circular_deque_unit
`default_nettype wire

### rtl/cdq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ctrl: request sequencer
// Accepts one request, waits in its read state for the store read, then hands the
// result to the output register once that register is free.
// ----------------------------------------------------------------------------
module cdq_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output cdq_pkg::cdq_cmd_t    cmd
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        cmd.exec = s_tvalid && s_tready;
        cmd.load = (state_reg == ST_READ) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.exec) state_next = ST_READ;
            end
            ST_READ: begin
                if (cmd.load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        priority if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule : cdq_ctrl
`default_nettype wire

### rtl/cdq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_datapath: pointers, store and result registers
// Holds head/tail/empty state and the word store; applies one request per
// exec command and drives the output register on load.
// ----------------------------------------------------------------------------
module cdq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire cdq_pkg::cdq_cmd_t            cmd,
    input  wire logic                         cfg_we,
    input  wire logic [cdq_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic [cdq_pkg::ACT_W-1:0]    req_action,
    input  wire logic [DATA_WIDTH-1:0]        req_data,
    output logic      [DATA_WIDTH-1:0]        rsp_data,
    output logic      [cdq_pkg::STAT_W-1:0]   rsp_status
);
    import cdq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W = $clog2(DEPTH + 1);
    localparam int CW    = (CAP_W > CFG_W) ? CAP_W : CFG_W;

    // Clamp a raw capacity into 1..DEPTH
    function automatic logic [CW-1:0] clamp_cap(input logic [CFG_W-1:0] raw);
        logic [CW-1:0] c;
        c = CW'(raw);
        if (c == '0) begin
            c = CW'(1);
        end else if (c > CW'(DEPTH)) begin
            c = CW'(DEPTH);
        end
        return c;
    endfunction

    logic [CW-1:0]         cap_reg;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic                  empty_reg, empty_next;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  pop_ok_reg, pop_ok_next;
    logic [STAT_W-1:0]     stat_reg, stat_next;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic [STAT_W-1:0]     out_stat_reg;

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [PTR_W-1:0]      rd_addr;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                                 input logic [CW-1:0] cap);
        logic [CW-1:0] pw;
        pw = CW'(p) + CW'(1);
        return (pw >= cap) ? '0 : PTR_W'(pw);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p,
                                                 input logic [CW-1:0] cap);
        logic [CW-1:0] lastp;
        lastp = cap - CW'(1);
        return (p == '0 || CW'(p) >= cap) ? PTR_W'(lastp) : p - PTR_W'(1);
    endfunction

    logic is_push, is_rear, full;

    always_comb begin
        is_push     = (req_action == ACT_PUSH_REAR) || (req_action == ACT_PUSH_FRONT);
        is_rear     = (req_action == ACT_PUSH_REAR) || (req_action == ACT_POP_REAR);
        full        = !empty_reg && (ptr_inc(tail_reg, cap_reg) == head_reg);

        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        stat_next   = STAT_OK;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        rd_addr     = is_rear ? tail_reg : head_reg;

        if (is_push) begin
            priority if (full) begin
                stat_next = STAT_OVERFLOW;
            end else if (empty_reg) begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b0;
                wr_en      = 1'b1;
                wr_addr    = '0;
            end else if (is_rear) begin
                tail_next = ptr_inc(tail_reg, cap_reg);
                wr_en     = 1'b1;
                wr_addr   = tail_next;
            end else begin
                head_next = ptr_dec(head_reg, cap_reg);
                wr_en     = 1'b1;
                wr_addr   = head_next;
            end
        end else begin
            priority if (empty_reg) begin
                stat_next = STAT_UNDERFLOW;
            end else begin
                pop_ok_next = 1'b1;
                priority if (head_reg == tail_reg) begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b1;
                end else if (is_rear) begin
                    tail_next = ptr_dec(tail_reg, cap_reg);
                end else begin
                    head_next = ptr_inc(head_reg, cap_reg);
                end
            end
        end
    end

    // Pointer and capacity state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= clamp_cap(CAP_RESET);
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end else if (cfg_we) begin
            cap_reg   <= clamp_cap(cfg_wdata);
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end else if (cmd.exec) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    // Word store: a write on each accepted push and a registered read per request
    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            mem[wr_addr] <= req_data;
        end
        if (cmd.exec) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Pending result and output register
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            pop_ok_reg <= pop_ok_next;
            stat_reg   <= stat_next;
        end
        if (cmd.load) begin
            out_data_reg <= pop_ok_reg ? rd_data_reg : '0;
            out_stat_reg <= stat_reg;
        end
    end

    assign rsp_data   = out_data_reg;
    assign rsp_status = out_stat_reg;

endmodule : cdq_datapath
`default_nettype wire
